// ----- hdl/wfrh_pkg.sv -----
// ----------------------------------------------------------------------------
// wfrh_pkg
// Shared constants, controller/datapath command types and the CORDIC angle
// table and gain correction, built at elaboration.
// ----------------------------------------------------------------------------
package wfrh_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int FRAC_BITS    = 16;
    localparam int TAB_LEN      = 32;
    localparam int RUN_STEPS    = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int CNT_W        = $clog2(TAB_LEN);

    // field widths
    localparam int PNT_W  = 48;
    localparam int HDG_W  = 25;
    // angle accumulator: degrees * 2^32, covers +/-512 degrees
    localparam int ANG_W  = 42;
    localparam int ANG_SH = 32 - FRAC_BITS;
    // sin/cos in Q30
    localparam int COEF_W = 32;
    // multiply-accumulate phases per map coordinate
    localparam int MAC_PHASES = 10;

    localparam longint ONE_DEG   = 64'sd1 <<< FRAC_BITS;
    localparam longint DEG180_F  = 180 * ONE_DEG;
    localparam longint DEG360_F  = 360 * ONE_DEG;
    localparam longint YAW_RESET = -90 * ONE_DEG;
    localparam longint DEG90_A   = 90 * (64'sd1 <<< 32);
    localparam longint DEG180_A  = 180 * (64'sd1 <<< 32);

    typedef logic [TAB_LEN-1:0][63:0] t_rom;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             load;
        logic             sc_init;
        logic             cordic_step;
        logic             rot_mode;
        logic [CNT_W-1:0] idx;
        logic             sc_fin;
        logic             mac;
        logic             mac_set;
        logic [3:0]       mac_phase;
        logic             hd_prep;
        logic             hd_sel;
        logic             hd_chk;
        logic             hd_norm;
        logic             hd_flip;
        logic             hd_fin;
        logic             done;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic valid;
        logic special;
        logic norm_done;
    } t_sts;

    // restoring unsigned divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(num * 2^bits / den), num < den
    function automatic logic [63:0] div_frac(input logic [63:0] num, input logic [63:0] den,
                                             input int bits);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = num;
        for (int i = 0; i < bits; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        if ((rem << 1) >= den)
            q = q + 64'd1;
        return q;
    endfunction

    // atan(1/m) in radians * 2^62 by its series
    function automatic logic signed [63:0] atan_inv(input logic [63:0] m);
        logic [63:0]        p;
        logic [63:0]        odd;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic               neg;
        p   = udiv64(64'd1 << 62, m);
        odd = 64'd1;
        sum = '0;
        neg = 1'b0;
        while (p != 64'd0) begin
            term = udiv64(p, odd);
            sum  = neg ? sum - $signed(term) : sum + $signed(term);
            neg  = !neg;
            odd  = odd + 64'd2;
            p    = udiv64(p, m * m);
        end
        return sum;
    endfunction

    function automatic t_rom build_rom();
        t_rom        r;
        logic [63:0] quarter;
        r       = '0;
        quarter = 64'(atan_inv(64'd2) + atan_inv(64'd3));
        r[0]    = 64'd45 << 32;
        for (int i = 1; i < TAB_LEN; i++)
            r[i] = div_frac(64'(atan_inv(64'd1 << i)), quarter, 32) * 64'd45;
        return r;
    endfunction

    function automatic logic signed [63:0] build_gain();
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] nx;
        logic signed [63:0] ny;
        logic signed [63:0] g;
        x = 64'sd1 <<< 60;
        y = '0;
        for (int i = 0; i < RUN_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
            end
            x = nx;
            y = ny;
        end
        if (x > (64'sd1 <<< 60))
            g = $signed(div_frac(64'd1 << 60, 64'(x), 60));
        else
            g = 64'sd1 <<< 60;
        return g;
    endfunction

    // atan(2^-i) in degrees * 2^32
    localparam t_rom               ATAN_ROM = build_rom();
    // 2^60 / CORDIC gain
    localparam logic signed [63:0] GAIN_FIX = build_gain();

endpackage

// ----- hdl/wfrh_ctrl.sv -----
// ----------------------------------------------------------------------------
// wfrh_ctrl
// Sequencer: yaw sine/cosine run, map rotation multiply-accumulate, then, when
// headings are due, two atan2 runs on the shared CORDIC datapath.
// ----------------------------------------------------------------------------
module wfrh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_out_free,
    input  wfrh_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output logic            o_out_load,
    output wfrh_pkg::t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_LOAD    = 13'b0000000000010,
        S_SC_INIT = 13'b0000000000100,
        S_SC_RUN  = 13'b0000000001000,
        S_SC_FIN  = 13'b0000000010000,
        S_MAC     = 13'b0000000100000,
        S_HD_PREP = 13'b0000001000000,
        S_HD_CHK  = 13'b0000010000000,
        S_HD_NORM = 13'b0000100000000,
        S_HD_FLIP = 13'b0001000000000,
        S_HD_RUN  = 13'b0010000000000,
        S_HD_FIN  = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } t_state;

    t_state                     r_state, n_state;
    logic [wfrh_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_sel, n_sel;
    logic                       step_last;
    logic                       mac_set;

    assign step_last = (r_cnt == wfrh_pkg::CNT_W'(wfrh_pkg::RUN_STEPS - 1));
    assign mac_set   = (r_cnt >= wfrh_pkg::CNT_W'(wfrh_pkg::MAC_PHASES));

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_sel         = r_sel;
        o_cmd         = '0;
        o_cmd.idx     = r_cnt;
        o_cmd.hd_sel  = r_sel;
        o_cmd.mac_set = mac_set;
        o_cmd.mac_phase = mac_set ?
            4'(r_cnt - wfrh_pkg::CNT_W'(wfrh_pkg::MAC_PHASES)) : 4'(r_cnt);
        o_in_ready    = 1'b0;
        o_out_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_SC_INIT;
            end
            S_SC_INIT: begin
                o_cmd.sc_init = 1'b1;
                n_cnt         = '0;
                n_state       = S_SC_RUN;
            end
            S_SC_RUN: begin
                o_cmd.cordic_step = 1'b1;
                o_cmd.rot_mode    = 1'b1;
                if (step_last) begin
                    n_cnt   = '0;
                    n_state = S_SC_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SC_FIN: begin
                o_cmd.sc_fin = 1'b1;
                n_cnt        = '0;
                n_state      = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                if (r_cnt == wfrh_pkg::CNT_W'(2 * wfrh_pkg::MAC_PHASES - 1)) begin
                    n_cnt   = '0;
                    n_sel   = 1'b0;
                    n_state = i_sts.valid ? S_HD_PREP : S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_HD_PREP: begin
                o_cmd.hd_prep = 1'b1;
                n_state       = S_HD_CHK;
            end
            S_HD_CHK: begin
                o_cmd.hd_chk = 1'b1;
                n_state      = i_sts.special ? S_HD_FIN : S_HD_NORM;
            end
            S_HD_NORM: begin
                o_cmd.hd_norm = 1'b1;
                if (i_sts.norm_done)
                    n_state = S_HD_FLIP;
            end
            S_HD_FLIP: begin
                o_cmd.hd_flip = 1'b1;
                n_cnt         = '0;
                n_state       = S_HD_RUN;
            end
            S_HD_RUN: begin
                o_cmd.cordic_step = 1'b1;
                if (step_last) begin
                    n_cnt   = '0;
                    n_state = S_HD_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_HD_FIN: begin
                o_cmd.hd_fin = 1'b1;
                if (r_sel) begin
                    n_state = S_DONE;
                end else begin
                    n_sel   = 1'b1;
                    n_state = S_HD_PREP;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.done = 1'b1;
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

endmodule

// ----- hdl/wfrh_dp.sv -----
// ----------------------------------------------------------------------------
// wfrh_dp
// Datapath: datum and previous-point state, relative offset, shared CORDIC
// (rotation and vectoring), one multiplier for the map rotation, heading
// rounding.
// ----------------------------------------------------------------------------
module wfrh_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wfrh_pkg::t_cmd                      i_cmd,
    output wfrh_pkg::t_sts                      o_sts,
    input  logic signed [wfrh_pkg::PNT_W-1:0]   i_point_x,
    input  logic signed [wfrh_pkg::PNT_W-1:0]   i_point_y,
    input  logic                                i_route_start,
    input  logic                                i_cfg_we,
    input  logic signed [wfrh_pkg::HDG_W-1:0]   i_cfg_yaw,
    output logic signed [wfrh_pkg::PNT_W-1:0]   o_rel_x,
    output logic signed [wfrh_pkg::PNT_W-1:0]   o_rel_y,
    output logic signed [wfrh_pkg::PNT_W-1:0]   o_map_x,
    output logic signed [wfrh_pkg::PNT_W-1:0]   o_map_y,
    output logic signed [wfrh_pkg::HDG_W-1:0]   o_heading_src,
    output logic signed [wfrh_pkg::HDG_W-1:0]   o_heading_map,
    output logic                                o_heading_valid
);

    localparam int PW = wfrh_pkg::PNT_W;
    localparam int AW = wfrh_pkg::ANG_W;
    localparam int CW = wfrh_pkg::COEF_W;

    localparam logic signed [PW-1:0] P_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] P_MIN = {1'b1, {(PW-1){1'b0}}};

    // saturate a 49-bit difference to 48 bits
    function automatic logic signed [PW-1:0] sat_p(input logic signed [PW:0] v);
        logic signed [PW-1:0] r;
        if (v[PW] != v[PW-1])
            r = v[PW] ? P_MIN : P_MAX;
        else
            r = v[PW-1:0];
        return r;
    endfunction

    // state and payload registers
    logic signed [24:0]   r_yaw;
    logic signed [PW-1:0] r_datum_x, r_datum_y;
    logic signed [PW-1:0] r_prev_rel_x, r_prev_rel_y, r_prev_map_x, r_prev_map_y;
    logic                 r_have_prev;
    logic signed [PW-1:0] r_px, r_py;
    logic                 r_start;
    logic                 r_valid;
    logic signed [PW-1:0] r_rel_x, r_rel_y, r_map_x, r_map_y;
    logic signed [wfrh_pkg::HDG_W-1:0] r_hs, r_hm;

    // CORDIC and rotation registers
    logic signed [63:0]   r_x, r_y, n_x, n_y;
    logic signed [AW-1:0] r_z, n_z, r_z0, n_z0;
    logic                 r_neg, n_neg;
    logic [63:0]          r_mag, n_mag;
    logic signed [CW-1:0] r_c, r_s;
    logic signed [57:0]   r_prod;
    logic signed [63:0]   r_acc_a, r_acc_b, r_t;

    // relative offset
    logic signed [PW-1:0] dsel_x, dsel_y;
    logic signed [PW:0]   dif_x, dif_y;
    assign dsel_x = r_start ? r_px : r_datum_x;
    assign dsel_y = r_start ? r_py : r_datum_y;
    assign dif_x  = {r_px[PW-1], r_px} - {dsel_x[PW-1], dsel_x};
    assign dif_y  = {r_py[PW-1], r_py} - {dsel_y[PW-1], dsel_y};

    // yaw wrapped to (-180, 180], then folded into +/-90 with a sign flag
    logic signed [25:0]   yaw_s, yaw_a;
    logic signed [AW-1:0] yaw_z, yaw_zf;
    logic                 yaw_neg;
    always_comb begin
        yaw_s = {r_yaw[24], r_yaw};
        if (yaw_s > 26'(wfrh_pkg::DEG180_F))
            yaw_a = yaw_s - 26'(wfrh_pkg::DEG360_F);
        else if (yaw_s <= -26'(wfrh_pkg::DEG180_F))
            yaw_a = yaw_s + 26'(wfrh_pkg::DEG360_F);
        else
            yaw_a = yaw_s;
        yaw_z   = AW'(yaw_a) <<< wfrh_pkg::ANG_SH;
        yaw_neg = 1'b0;
        yaw_zf  = yaw_z;
        if (yaw_z > AW'(wfrh_pkg::DEG90_A)) begin
            yaw_zf  = yaw_z - AW'(wfrh_pkg::DEG180_A);
            yaw_neg = 1'b1;
        end else if (yaw_z < -AW'(wfrh_pkg::DEG90_A)) begin
            yaw_zf  = yaw_z + AW'(wfrh_pkg::DEG180_A);
            yaw_neg = 1'b1;
        end
    end

    // one CORDIC micro-rotation
    logic signed [63:0]   xs, ys;
    logic signed [AW-1:0] rom_a;
    logic                 dir;
    assign xs    = r_x >>> i_cmd.idx;
    assign ys    = r_y >>> i_cmd.idx;
    assign rom_a = $signed(wfrh_pkg::ATAN_ROM[i_cmd.idx][AW-1:0]);
    assign dir   = i_cmd.rot_mode ? !r_z[AW-1] : r_y[63];

    // sine/cosine rounding to Q30
    logic signed [63:0] c_rnd, s_rnd;
    assign c_rnd = (r_x + 64'sd536870912) >>> 30;
    assign s_rnd = (r_y + 64'sd536870912) >>> 30;

    // multiplier operands
    logic [1:0]           mul_idx;
    logic signed [PW-1:0] coord;
    logic signed [24:0]   opnd;
    logic signed [CW:0]   c33, s33, coef;
    assign mul_idx = i_cmd.mac_phase[2:1];
    assign coord   = mul_idx[0] ? r_rel_y : r_rel_x;
    assign opnd    = mul_idx[1] ? $signed({1'b0, coord[23:0]})
                                : $signed({coord[PW-1], coord[PW-1:24]});
    assign c33     = {r_c[CW-1], r_c};
    assign s33     = {r_s[CW-1], r_s};
    assign coef    = mul_idx[0] ? (i_cmd.mac_set ? c33 : -s33)
                                : (i_cmd.mac_set ? s33 : c33);

    // rotation result: high part shifted plus rounded low part
    logic signed [63:0] mac_sum;
    logic signed [PW-1:0] mac_res;
    always_comb begin
        mac_sum = (r_acc_a >>> 6) + (r_t >>> 30);
        if (mac_sum > 64'(P_MAX))
            mac_res = P_MAX;
        else if (mac_sum < 64'(P_MIN))
            mac_res = P_MIN;
        else
            mac_res = mac_sum[PW-1:0];
    end

    // segment deltas
    logic signed [PW-1:0] hd_cx, hd_cy, hd_px, hd_py;
    logic signed [PW:0]   hd_dx, hd_dy;
    assign hd_cx = i_cmd.hd_sel ? r_map_x : r_rel_x;
    assign hd_cy = i_cmd.hd_sel ? r_map_y : r_rel_y;
    assign hd_px = i_cmd.hd_sel ? r_prev_map_x : r_prev_rel_x;
    assign hd_py = i_cmd.hd_sel ? r_prev_map_y : r_prev_rel_y;
    assign hd_dx = {hd_cx[PW-1], hd_cx} - {hd_px[PW-1], hd_px};
    assign hd_dy = {hd_cy[PW-1], hd_cy} - {hd_py[PW-1], hd_py};

    logic        x_zero, y_zero;
    logic [63:0] ax, ay;
    assign x_zero = (r_x == 64'sd0);
    assign y_zero = (r_y == 64'sd0);
    assign ax     = r_x[63] ? 64'(-r_x) : 64'(r_x);
    assign ay     = r_y[63] ? 64'(-r_y) : 64'(r_y);

    // heading rounding and clamp
    logic signed [AW:0]   z_sum, z_rnd;
    logic signed [wfrh_pkg::HDG_W-1:0] hd_res;
    always_comb begin
        z_sum = {r_z[AW-1], r_z} + {r_z0[AW-1], r_z0};
        z_rnd = (z_sum + (AW+1)'(64'sd1 <<< (wfrh_pkg::ANG_SH - 1))) >>> wfrh_pkg::ANG_SH;
        if (z_rnd > (AW+1)'(wfrh_pkg::DEG180_F))
            hd_res = wfrh_pkg::HDG_W'(wfrh_pkg::DEG180_F);
        else if (z_rnd < -(AW+1)'(wfrh_pkg::DEG180_F))
            hd_res = -wfrh_pkg::HDG_W'(wfrh_pkg::DEG180_F);
        else
            hd_res = z_rnd[wfrh_pkg::HDG_W-1:0];
    end

    // CORDIC register next values
    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_z   = r_z;
        n_z0  = r_z0;
        n_neg = r_neg;
        n_mag = r_mag;
        if (i_cmd.sc_init) begin
            n_x   = wfrh_pkg::GAIN_FIX;
            n_y   = '0;
            n_z   = yaw_zf;
            n_neg = yaw_neg;
        end else if (i_cmd.cordic_step) begin
            if (dir) begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - rom_a;
            end else begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + rom_a;
            end
        end else if (i_cmd.hd_prep) begin
            n_x = 64'(hd_dx);
            n_y = 64'(hd_dy);
        end else if (i_cmd.hd_chk) begin
            // axis-aligned and zero-length segments are exact
            n_z0  = '0;
            n_mag = (ax > ay) ? ax : ay;
            if (y_zero)
                n_z = r_x[63] ? AW'(wfrh_pkg::DEG180_A) : '0;
            else if (x_zero)
                n_z = r_y[63] ? -AW'(wfrh_pkg::DEG90_A) : AW'(wfrh_pkg::DEG90_A);
        end else if (i_cmd.hd_norm && !o_sts.norm_done) begin
            if (r_mag < (64'd1 << 51)) begin
                n_x   = r_x <<< 8;
                n_y   = r_y <<< 8;
                n_mag = r_mag << 8;
            end else begin
                n_x   = r_x <<< 1;
                n_y   = r_y <<< 1;
                n_mag = r_mag << 1;
            end
        end else if (i_cmd.hd_flip) begin
            // left half-plane: mirror through the origin, add +/-180 at the end
            n_z  = '0;
            n_z0 = '0;
            if (r_x[63]) begin
                n_x  = -r_x;
                n_y  = -r_y;
                n_z0 = (r_y > 64'sd0) ? AW'(wfrh_pkg::DEG180_A) : -AW'(wfrh_pkg::DEG180_A);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_z0  <= n_z0;
        r_neg <= n_neg;
        r_mag <= n_mag;
    end

    // configuration and route state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw        <= 25'(wfrh_pkg::YAW_RESET);
            r_datum_x    <= '0;
            r_datum_y    <= '0;
            r_prev_rel_x <= '0;
            r_prev_rel_y <= '0;
            r_prev_map_x <= '0;
            r_prev_map_y <= '0;
            r_have_prev  <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_yaw <= i_cfg_yaw;
            if (i_cmd.load) begin
                r_valid <= r_have_prev && !r_start;
                if (r_start) begin
                    r_datum_x <= r_px;
                    r_datum_y <= r_py;
                end
            end
            if (i_cmd.done) begin
                r_prev_rel_x <= r_rel_x;
                r_prev_rel_y <= r_rel_y;
                r_prev_map_x <= r_map_x;
                r_prev_map_y <= r_map_y;
                r_have_prev  <= 1'b1;
            end
        end
    end

    // payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px    <= i_point_x;
            r_py    <= i_point_y;
            r_start <= i_route_start;
        end
        if (i_cmd.load) begin
            r_rel_x <= sat_p(dif_x);
            r_rel_y <= sat_p(dif_y);
            r_hs    <= '0;
            r_hm    <= '0;
        end
        if (i_cmd.sc_fin) begin
            r_c <= CW'(r_neg ? -c_rnd : c_rnd);
            r_s <= CW'(r_neg ? -s_rnd : s_rnd);
        end
        if (i_cmd.mac) begin
            if (i_cmd.mac_phase < 4'd8) begin
                if (!i_cmd.mac_phase[0]) begin
                    r_prod <= opnd * coef;
                end else if (!mul_idx[1]) begin
                    r_acc_a <= mul_idx[0] ? r_acc_a + 64'(r_prod) : 64'(r_prod);
                end else begin
                    r_acc_b <= mul_idx[0] ? r_acc_b + 64'(r_prod) : 64'(r_prod);
                end
            end else if (!i_cmd.mac_phase[0]) begin
                r_t <= $signed({34'd0, r_acc_a[5:0], 24'd0}) + r_acc_b + 64'sd536870912;
            end else if (i_cmd.mac_set) begin
                r_map_y <= mac_res;
            end else begin
                r_map_x <= mac_res;
            end
        end
        if (i_cmd.hd_fin) begin
            if (i_cmd.hd_sel)
                r_hm <= hd_res;
            else
                r_hs <= hd_res;
        end
    end

    assign o_sts.valid     = r_valid;
    assign o_sts.special   = x_zero || y_zero;
    assign o_sts.norm_done = |r_mag[63:59];

    assign o_rel_x         = r_rel_x;
    assign o_rel_y         = r_rel_y;
    assign o_map_x         = r_map_x;
    assign o_map_y         = r_map_y;
    assign o_heading_src   = r_hs;
    assign o_heading_map   = r_hm;
    assign o_heading_valid = r_valid;

endmodule

// ----- hdl/waypoint_frame_rotate_heading_top.sv -----
// ----------------------------------------------------------------------------
// waypoint_frame_rotate_heading_top
// Waypoint offset from datum, rotation into the map frame and segment
// headings in both frames by CORDIC.
//
//  channel  | dir | handshake               | words
//  ---------+-----+-------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | one waypoint
//  m_axis   | out | m_axis_tvalid/tready    | offsets, map point, headings
//  cfg      | in  | i_cfg_valid/o_cfg_ready | frame yaw, always ready
//
// One waypoint at a time; an axis or zero-length segment skips its heading run.
// The shared CORDIC unit (up to three runs of 20 steps) and the single
// multiplier (8 products) are used in turn for each waypoint.
// Synchronous active-low reset; a held result stalls the sequencer, so the next
// waypoint is not accepted until the output register is free.
// ----------------------------------------------------------------------------
module waypoint_frame_rotate_heading_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // point_x, point_y
    input  logic [0:0]   s_axis_tuser,   // route_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rel_x, rel_y, map_x, map_y, heading_src, heading_map, zero pad
    output logic [247:0] m_axis_tdata,
    output logic [0:0]   m_axis_tuser,   // heading_valid
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [24:0]  i_cfg_data      // frame_yaw_deg
);

    wfrh_pkg::t_cmd cmd;
    wfrh_pkg::t_sts sts;
    logic           in_ready, in_fire, out_load, out_free;

    logic signed [wfrh_pkg::PNT_W-1:0] rel_x, rel_y, map_x, map_y;
    logic signed [wfrh_pkg::HDG_W-1:0] hd_src, hd_map;
    logic                              hd_valid;

    logic         r_out_valid;
    logic [247:0] r_out_data;
    logic         r_out_user;

    assign s_axis_tready = in_ready;
    assign in_fire       = s_axis_tvalid && in_ready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    wfrh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_out_load (out_load),
        .o_cmd      (cmd)
    );

    wfrh_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_point_x       ($signed(s_axis_tdata[47:0])),
        .i_point_y       ($signed(s_axis_tdata[95:48])),
        .i_route_start   (s_axis_tuser[0]),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_yaw       ($signed(i_cfg_data)),
        .o_rel_x         (rel_x),
        .o_rel_y         (rel_y),
        .o_map_x         (map_x),
        .o_map_y         (map_y),
        .o_heading_src   (hd_src),
        .o_heading_map   (hd_map),
        .o_heading_valid (hd_valid)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {6'd0, hd_map, hd_src, map_y, map_x, rel_y, rel_x};
            r_out_user <= hd_valid;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_user;

    // a finished word never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || m_axis_tready))
        else $error("output word overwritten");

    // one waypoint in flight: no accept in the cycle after an accept
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !s_axis_tready)
        else $error("second waypoint accepted while busy");

    // headings are zero when no previous point exists or a route starts
    a_heading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[241:192] == 50'd0))
        else $error("heading without previous point");

endmodule
